// ----- hdl/wmr_pkg.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// wmr_pkg
// Shared types and fixed formats of the running mean and rms block.
// -----------------------------------------------------------------------------
package wmr_pkg;

	// fraction bits of the running mean, in units of one sample step
	localparam int MEAN_FRAC    = 16;
	// rounding shift applied to each deviation factor before the product
	localparam int FACTOR_SHIFT = 10;
	// width of the sum of squared deviations
	localparam int QW           = 56;
	// the root carries 6 extra fraction bits over the Q16.0 rms result
	localparam int ROOT_SHIFT   = 6;
	// result field widths
	localparam int MEAN_W       = 16;
	localparam int RMS_W        = 16;
	localparam int CNT_OUT_W    = 13;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_FACTOR,
		ST_MUL,
		ST_ACC,
		ST_CLOSE,
		ST_VAR_WAIT,
		ST_ROOT_WAIT,
		ST_OUT
	} wmr_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} wmr_unit_stat_t;

endpackage

`default_nettype wire

// ----- hdl/wmr_div.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// wmr_div
// Restoring divider, one quotient bit per cycle. The dividend arrives
// left-aligned; LW-wide steps sets how many of its top bits are used.
// -----------------------------------------------------------------------------
module wmr_div
	import wmr_pkg::*;
#(
	parameter int NW = 56,
	parameter int CW = 13,
	parameter int LW = 6
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] dividend,
	input  wire logic [CW-1:0] divisor,
	input  wire logic [LW-1:0] steps,
	output logic      [NW-1:0] quotient,
	output wmr_unit_stat_t     stat
);

	logic [NW-1:0] z_q;
	logic [CW-1:0] r_q;
	logic [CW-1:0] dv_q;
	logic [LW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	logic [CW:0]   rs;
	logic          ge;
	logic [CW:0]   diff;

	always_comb begin
		rs   = {r_q, z_q[NW-1]};
		ge   = rs >= {1'b0, dv_q};
		diff = rs - {1'b0, dv_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - LW'(1);
				if (cnt_q == LW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			z_q  <= dividend;
			r_q  <= '0;
			dv_q <= divisor;
		end else if (busy_q) begin
			// remainder stays below the divisor, so CW bits hold it
			r_q <= ge ? diff[CW-1:0] : rs[CW-1:0];
			z_q <= {z_q[NW-2:0], ge};
		end
	end

	assign quotient  = z_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

`default_nettype wire

// ----- hdl/wmr_isqrt.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// wmr_isqrt
// Floor integer square root, one result bit per cycle.
// -----------------------------------------------------------------------------
module wmr_isqrt
	import wmr_pkg::*;
#(
	parameter int TW = 56
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic [TW-1:0]   radicand,
	output logic      [TW/2-1:0] root,
	output wmr_unit_stat_t       stat
);

	logic [TW-1:0] x_q;
	logic [TW-1:0] r_q;
	logic [TW-1:0] bit_q;
	logic          busy_q;
	logic          done_q;

	logic [TW-1:0] trial;
	logic          fits;

	always_comb begin
		trial = r_q + bit_q;
		fits  = x_q >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= radicand;
			r_q   <= '0;
			bit_q <= TW'(1) << (TW - 2);
		end else if (busy_q) begin
			if (fits) begin
				x_q <= x_q - trial;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign root      = r_q[TW/2-1:0];
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

`default_nettype wire

// ----- hdl/welford_mean_and_rms.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// welford_mean_and_rms
// Running Welford mean and sample standard deviation of a waveform window.
// -----------------------------------------------------------------------------
// Each sample beat updates the running mean (16 fraction bits) and the sum of
// squared deviations through one shared bit-serial divider and one
// multiplier. The divider yields one quotient bit per cycle over
// SAMPLE_BITS + 17 numerator bits, and tready stays low until the sample is
// fully folded in. When the window holds more than one sample, the beat with
// tlast adds a 56-step division of the sum by n - 1 in the same divider, then
// a 28-step square root. The result beat then waits in an output register,
// and the block accepts the next window meanwhile. Samples beyond MAX_SAMPLES
// are dropped; tlast still closes the window.
module welford_mean_and_rms
	import wmr_pkg::*;
#(
	parameter int MAX_SAMPLES = 4096,
	parameter int SAMPLE_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,   // [15:0] sample
	input  wire logic        s_axis_tlast,   // last
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [47:0] m_axis_tdata    // [15:0] mean, [31:16] rms,
	                                         // [44:32] sample_count, rest zero
);

	localparam int CW   = $clog2(MAX_SAMPLES + 1);
	localparam int MW   = SAMPLE_BITS + MEAN_FRAC;
	localparam int DW   = MW + 1;
	localparam int FW   = DW - FACTOR_SHIFT;
	localparam int PW   = 2 * FW;
	localparam int NW   = (QW > DW) ? QW : DW;
	localparam int LW   = $clog2(NW + 1);
	localparam int SW   = ((PW > QW) ? PW : QW) + 1;
	localparam int RW   = SAMPLE_BITS + 1;
	localparam int RTW  = QW / 2;

	wmr_state_t state_q, state_d;

	// window state
	logic signed [MW-1:0]  mean_q;
	logic        [QW-1:0]  q_q;
	logic        [CW-1:0]  count_q;

	// per-sample working registers
	logic signed [SAMPLE_BITS-1:0] s_q;
	logic                          last_q;
	logic        [DW-1:0]          mag_q;
	logic                          neg_q;
	logic        [FW-1:0]          f1_q;
	logic        [FW-1:0]          f2_q;
	logic        [PW-1:0]          prod_q;

	// output register
	logic        out_valid_q;
	logic [47:0] out_data_q;

	// control
	logic in_accept;
	logic full;
	logic multi;
	logic div_start;
	logic div_var;
	logic sqrt_start;
	logic out_load;

	wmr_unit_stat_t div_stat;
	wmr_unit_stat_t sqrt_stat;

	logic [NW-1:0]  div_dividend;
	logic [CW-1:0]  div_divisor;
	logic [LW-1:0]  div_steps;
	logic [NW-1:0]  div_quot;
	logic [RTW-1:0] root;

	// datapath
	logic signed [DW-1:0] d_w;
	logic signed [DW-1:0] diff_old;
	logic signed [DW-1:0] diff_new;
	logic        [DW-1:0] mag_new;
	logic        [CW-1:0] n_w;
	logic        [DW-1:0] num_w;
	logic signed [DW-1:0] step_w;
	logic signed [DW-1:0] anew_w;
	logic        [SW-1:0] qsum;
	logic        [QW-1:0] q_next;
	logic        [MW-1:0] mean_mag;
	logic        [RW-1:0] mean_rnd;
	logic        [16:0]   mean_sat;
	logic        [15:0]   mean_out;
	logic        [RTW:0]  rms_rnd;
	logic        [15:0]   rms_out;

	assign in_accept = s_axis_tvalid && s_axis_tready;
	assign full      = count_q == CW'(MAX_SAMPLES);
	assign multi     = count_q > CW'(1);

	always_comb begin
		d_w      = DW'($signed({s_q, {MEAN_FRAC{1'b0}}}));
		diff_old = d_w - DW'(mean_q);
		diff_new = d_w - DW'(mean_q);
		mag_new  = diff_new[DW-1] ? DW'(-diff_new) : DW'(diff_new);
		n_w      = count_q + CW'(1);
		num_w    = mag_q + DW'(n_w >> 1);
		step_w   = neg_q ? -$signed(div_quot[DW-1:0]) : $signed(div_quot[DW-1:0]);
		anew_w   = DW'(mean_q) + step_w;
		qsum     = SW'(q_q) + SW'(prod_q);
		q_next   = (qsum > SW'({QW{1'b1}})) ? {QW{1'b1}} : qsum[QW-1:0];
	end

	// mean rounded to a signed 16-bit integer (Q16.0), ties away from zero, clamped to 16 bits
	always_comb begin
		mean_mag = mean_q[MW-1] ? MW'(-mean_q) : MW'(mean_q);
		mean_rnd = RW'((MW'(mean_mag) + MW'(1 << (MEAN_FRAC - 1))) >> MEAN_FRAC);
		if (mean_q[MW-1]) begin
			mean_sat = (32'(mean_rnd) > 32'd32768) ? 17'd32768 : 17'(mean_rnd);
			mean_out = 16'(-mean_sat);
		end else begin
			mean_sat = (32'(mean_rnd) > 32'd32767) ? 17'd32767 : 17'(mean_rnd);
			mean_out = mean_sat[15:0];
		end
		rms_rnd = ((RTW + 1)'(root) + (RTW + 1)'(1 << (ROOT_SHIFT - 1))) >> ROOT_SHIFT;
		if (!multi) begin
			rms_out = '0;
		end else if (rms_rnd > (RTW + 1)'(16'hFFFF)) begin
			rms_out = 16'hFFFF;
		end else begin
			rms_out = rms_rnd[15:0];
		end
	end

	// shared divider: mean step or variance, chosen by state
	always_comb begin
		if (div_var) begin
			div_dividend = NW'(q_q) << (NW - QW);
			div_divisor  = count_q - CW'(1);
			div_steps    = LW'(QW);
		end else begin
			div_dividend = NW'(num_w) << (NW - DW);
			div_divisor  = n_w;
			div_steps    = LW'(DW);
		end
	end

	wmr_div #(
		.NW(NW),
		.CW(CW),
		.LW(LW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.steps    (div_steps),
		.quotient (div_quot),
		.stat     (div_stat)
	);

	wmr_isqrt #(
		.TW(QW)
	) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (div_quot[QW-1:0]),
		.root     (root),
		.stat     (sqrt_stat)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					if (!full) begin
						state_d = ST_PREP;
					end else if (s_axis_tlast) begin
						state_d = ST_CLOSE;
					end
				end
			end
			ST_PREP:      state_d = ST_DIV_START;
			ST_DIV_START: state_d = ST_DIV_WAIT;
			ST_DIV_WAIT:  if (div_stat.done) state_d = ST_FACTOR;
			ST_FACTOR:    state_d = ST_MUL;
			ST_MUL:       state_d = ST_ACC;
			ST_ACC:       state_d = last_q ? ST_CLOSE : ST_IDLE;
			ST_CLOSE:     state_d = multi ? ST_VAR_WAIT : ST_OUT;
			ST_VAR_WAIT:  if (div_stat.done) state_d = ST_ROOT_WAIT;
			ST_ROOT_WAIT: if (sqrt_stat.done) state_d = ST_OUT;
			ST_OUT:       if (!out_valid_q || m_axis_tready) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_axis_tready = state_q == ST_IDLE;
		div_var       = state_q == ST_CLOSE;
		div_start     = (state_q == ST_DIV_START) || (state_q == ST_CLOSE && multi);
		sqrt_start    = (state_q == ST_VAR_WAIT) && div_stat.done;
		out_load      = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mean_q      <= '0;
			q_q         <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DIV_WAIT && div_stat.done) begin
				mean_q <= MW'(anew_w);
			end
			if (state_q == ST_ACC) begin
				q_q     <= q_next;
				count_q <= n_w;
			end
			if (out_load) begin
				// clear for the next window
				mean_q  <= '0;
				q_q     <= '0;
				count_q <= '0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			s_q    <= SAMPLE_BITS'(s_axis_tdata);
			last_q <= s_axis_tlast;
		end
		if (state_q == ST_PREP) begin
			neg_q <= diff_old[DW-1];
			mag_q <= diff_old[DW-1] ? DW'(-diff_old) : DW'(diff_old);
		end
		if (state_q == ST_DIV_START) begin
			f2_q <= FW'((mag_q + DW'(1 << (FACTOR_SHIFT - 1))) >> FACTOR_SHIFT);
		end
		if (state_q == ST_FACTOR) begin
			f1_q <= FW'((mag_new + DW'(1 << (FACTOR_SHIFT - 1))) >> FACTOR_SHIFT);
		end
		if (state_q == ST_MUL) begin
			prod_q <= PW'(f1_q) * PW'(f2_q);
		end
		if (out_load) begin
			out_data_q <= {3'b000, CNT_OUT_W'(count_q), rms_out, mean_out};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_SAMPLES))
		else $error("sample count beyond window limit");

	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider restarted while busy");

	a_div_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == ST_DIV_WAIT || state_q == ST_VAR_WAIT))
		else $error("divider result with no state waiting for it");

	a_sqrt_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		sqrt_stat.done |-> state_q == ST_ROOT_WAIT)
		else $error("root result with no state waiting for it");

	a_clear_after_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (count_q == '0 && m_axis_tvalid))
		else $error("window not cleared after result load");

endmodule

`default_nettype wire

// ----- verif/welford_mean_and_rms_test.sv -----
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// welford_mean_and_rms_test
// Self-checking bench for the running mean and rms block. Sample beats go in
// with random gaps and the result side stalls at random, save in steady runs.
// A bit-exact fixed-point model of the Welford update predicts every window's
// mean, rms and count, and each result beat is held to the oldest prediction.
// -----------------------------------------------------------------------------
module welford_mean_and_rms_test;
	import wmr_pkg::*;

	localparam int          WINDOW_MAX   = 4096;
	localparam int          RANDOM_BEATS = 1900;
	localparam int          CYCLE_LIMIT  = 4_000_000;
	localparam int          DRAIN_CYCLES = 200;
	localparam longint unsigned SUM_SQ_MAX = (64'd1 << QW) - 64'd1;

	typedef struct packed {
		logic [MEAN_W-1:0]    mean;
		logic [RMS_W-1:0]     rms;
		logic [CNT_OUT_W-1:0] count;
	} window_stats_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;    // [15:0] sample
	logic        s_axis_tlast = 1'b0;  // last
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;         // [15:0] mean, [31:16] rms, [44:32] sample_count

	// running state of the model
	longint          mean_acc;
	longint unsigned sum_sq_acc;
	int unsigned     window_len;

	window_stats_t expected_stats[$];
	bit            steady_flow = 1'b0;
	int unsigned   fault_count = 0;
	int unsigned   samples_sent = 0;
	int unsigned   windows_closed = 0;
	int unsigned   windows_checked = 0;
	int unsigned   drain_wait = 0;

	welford_mean_and_rms #(
		.MAX_SAMPLES(WINDOW_MAX),
		.SAMPLE_BITS(16)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Timeout: %0d results still outstanding", expected_stats.size());
		$display("Test completed with failures");
		$finish;
	end

	// divide and round to nearest, ties away from zero
	function automatic longint div_nearest(longint num, longint unsigned den);
		longint unsigned mag;
		longint unsigned quo;
		mag = (num < 0) ? longint'(-num) : longint'(num);
		quo = (mag + den / 2) / den;
		return (num < 0) ? -longint'(quo) : longint'(quo);
	endfunction

	function automatic longint shift_nearest(longint num, int sh);
		longint unsigned mag;
		longint unsigned quo;
		mag = (num < 0) ? longint'(-num) : longint'(num);
		quo = (mag + (64'd1 << (sh - 1))) >> sh;
		return (num < 0) ? -longint'(quo) : longint'(quo);
	endfunction

	function automatic longint unsigned floor_sqrt(longint unsigned x);
		longint unsigned root;
		longint unsigned probe;
		root = 0;
		probe = 64'd1 << 62;
		while (probe > x)
			probe >>= 2;
		while (probe != 0) begin
			if (x >= root + probe) begin
				x -= root + probe;
				root = (root >> 1) + probe;
			end else begin
				root >>= 1;
			end
			probe >>= 2;
		end
		return root;
	endfunction

	// fold one accepted beat into the model; a last beat closes the window
	function automatic void fold_sample(logic signed [15:0] value, bit last_flag);
		longint          scaled;
		longint          mean_next;
		longint          dev_new;
		longint          dev_old;
		longint unsigned prod;
		longint          mean_out;
		longint unsigned rms_out;
		window_stats_t   stats;
		samples_sent++;
		if (window_len < WINDOW_MAX) begin
			scaled    = longint'(value) * (64'sd1 <<< MEAN_FRAC);
			mean_next = mean_acc + div_nearest(scaled - mean_acc, window_len + 1);
			dev_new   = shift_nearest(scaled - mean_next, FACTOR_SHIFT);
			dev_old   = shift_nearest(scaled - mean_acc, FACTOR_SHIFT);
			if (dev_new < 0) dev_new = -dev_new;
			if (dev_old < 0) dev_old = -dev_old;
			prod = longint'(dev_new) * longint'(dev_old);
			if (prod > SUM_SQ_MAX - sum_sq_acc)
				sum_sq_acc = SUM_SQ_MAX;
			else
				sum_sq_acc += prod;
			mean_acc = mean_next;
			window_len++;
		end
		if (!last_flag)
			return;
		mean_out = shift_nearest(mean_acc, MEAN_FRAC);
		if (mean_out > 32767) mean_out = 32767;
		if (mean_out < -32768) mean_out = -32768;
		rms_out = 0;
		if (window_len > 1) begin
			rms_out = (floor_sqrt(sum_sq_acc / (window_len - 1)) + 32) >> ROOT_SHIFT;
			if (rms_out > 65535) rms_out = 65535;
		end
		stats.mean  = mean_out[MEAN_W-1:0];
		stats.rms   = rms_out[RMS_W-1:0];
		stats.count = window_len[CNT_OUT_W-1:0];
		expected_stats = {expected_stats, stats};
		windows_closed++;
		mean_acc   = 0;
		sum_sq_acc = 0;
		window_len = 0;
	endfunction

	task automatic send_sample(input logic signed [15:0] value, input bit last_flag);
		int unsigned gap;
		gap = steady_flow ? 0 : $urandom_range(0, 7);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= value;
		s_axis_tlast  <= last_flag;
		do @(posedge clk); while (!s_axis_tready);
		fold_sample(value, last_flag);
	endtask

	// drop valid before waiting on the clock
	task automatic stop_sending();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	// result side: stall at random after each beat, unless the flow is steady
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			drain_wait = steady_flow ? 0 : $urandom_range(0, 7);
		if (drain_wait != 0) begin
			drain_wait--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		window_stats_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_stats.size() == 0) begin
				$error("result beat with no window pending: tdata %h", m_axis_tdata);
				fault_count++;
			end else begin
				want = expected_stats.pop_front();
				windows_checked++;
				if (m_axis_tdata[15:0] !== want.mean) begin
					$error("mean: expected %0d, got %0d", $signed(want.mean),
						$signed(m_axis_tdata[15:0]));
					fault_count++;
				end
				if (m_axis_tdata[31:16] !== want.rms) begin
					$error("rms: expected %0d, got %0d", want.rms, m_axis_tdata[31:16]);
					fault_count++;
				end
				if (m_axis_tdata[44:32] !== want.count) begin
					$error("sample_count: expected %0d, got %0d", want.count,
						m_axis_tdata[44:32]);
					fault_count++;
				end
			end
		end
	end

	// one-sample windows: rms must read 0
	task automatic test_single_sample();
		send_sample(16'sh7FFF, 1'b1);
		send_sample(-16'sh8000, 1'b1);
		send_sample(16'sh0000, 1'b1);
		send_sample(-16'sh0001, 1'b1);
		stop_sending();
	endtask

	// full-scale spread and mean rounding on half steps
	task automatic test_extremes_and_ties();
		send_sample(-16'sh8000, 1'b0);
		send_sample(16'sh7FFF, 1'b1);
		send_sample(16'sh7FFF, 1'b0);
		send_sample(16'sh7FFF, 1'b1);
		send_sample(16'sh0001, 1'b0);
		send_sample(16'sh0002, 1'b1);
		send_sample(-16'sh0001, 1'b0);
		send_sample(-16'sh0002, 1'b1);
		stop_sending();
	endtask

	task automatic test_ramp();
		for (int k = 0; k < 10; k++)
			send_sample(16'(k * 37 - 100), k == 9);
		stop_sending();
	endtask

	task automatic test_random_windows();
		int unsigned     start;
		int unsigned     len;
		int unsigned     pick;
		int unsigned     style;
		logic     [15:0] base;
		logic     [15:0] value;
		start = samples_sent;
		while (samples_sent - start < RANDOM_BEATS) begin
			pick = $urandom_range(0, 99);
			if (pick < 80)
				len = $urandom_range(1, 8);
			else if (pick < 95)
				len = $urandom_range(9, 40);
			else if (pick < 99)
				len = $urandom_range(41, 150);
			else
				len = $urandom_range(151, 500);
			style       = $urandom_range(0, 3);
			base        = 16'($urandom_range(0, 65535));
			steady_flow = ($urandom_range(0, 4) == 0);
			for (int k = 0; k < len; k++) begin
				case (style)
					0: value = 16'($urandom_range(0, 65535));
					1: value = base + 16'($urandom_range(0, 63)) - 16'd32;
					2: value = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
					default: value = base;
				endcase
				send_sample(value, k == len - 1);
			end
		end
		steady_flow = 1'b0;
		stop_sending();
	endtask

	initial begin
		mean_acc   = 0;
		sum_sq_acc = 0;
		window_len = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_single_sample();
		test_extremes_and_ties();
		test_ramp();
		test_random_windows();

		wait (expected_stats.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d samples in %0d windows, %0d results checked,",
			samples_sent, windows_closed, windows_checked);
		$display("over one-sample windows, full-scale extremes, rounding ties and random runs.");
		if (fault_count == 0 && expected_stats.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
